### hw/rtl/scit_pkg.sv
// ----------------------------------------------------------------------------
// Calibration table package
// Shared widths, constants, status codes, the arctangent table and the
// command/status structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package scit_pkg;

  // Field widths.
  localparam int FREQ_W = 33;
  localparam int CORR_W = 16;
  localparam int ANG_W  = 15;
  localparam int STAT_W = 2;

  // CORDIC datapath sizing.
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = 4;
  localparam int XY_W         = 25;
  localparam int Z_W          = 24;
  localparam int ATAN_W       = 21;
  localparam int XY_INIT      = 1790862;

  // Angle limits in 1/64 degree.
  localparam int FULL_TURN    = 23040;
  localparam int HALF_TURN    = 11520;
  localparam int QUARTER_TURN = 5760;
  localparam int PHASE_LIMIT  = 11520;
  localparam int CORR_LIMIT   = 23040;

  // Interpolation product and serial divider.
  localparam int PROD_W    = 49;
  localparam int DIV_CNT_W = 6;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    STATUS_QUERY   = 2'd0,
    STATUS_UPDATED = 2'd1,
    STATUS_ADDED   = 2'd2,
    STATUS_FULL    = 2'd3
  } status_t;

  // Result source selection.
  typedef enum logic [2:0] {
    RES_ZERO   = 3'd0,
    RES_ADD    = 3'd1,
    RES_CUR    = 3'd2,
    RES_PREV   = 3'd3,
    RES_INTERP = 3'd4
  } res_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;
    logic     cordic_step;
    logic     rd_scan;
    logic     scan_next;
    logic     shift_init;
    logic     rd_shift;
    logic     shift_wr;
    logic     new_wr;
    logic     count_inc;
    logic     mul;
    logic     div_step;
    logic     res_load;
    res_sel_t res_sel;
    status_t  status;
    logic     out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic query;
    logic enable;
    logic empty;
    logic full;
    logic cordic_last;
    logic at_end;
    logic hit;
    logic eq;
    logic first;
    logic shift_last;
    logic div_last;
    logic out_busy;
  } sts_t;

  // Arctangent of 2^-i in 1/16384 degree.
  function automatic logic [ATAN_W-1:0] atan_angle(input logic [STEP_W-1:0] step);
    logic [ATAN_W-1:0] a;
    unique case (step)
      4'd0:  a = 21'd737280;
      4'd1:  a = 21'd435242;
      4'd2:  a = 21'd229970;
      4'd3:  a = 21'd116736;
      4'd4:  a = 21'd58595;
      4'd5:  a = 21'd29326;
      4'd6:  a = 21'd14667;
      4'd7:  a = 21'd7334;
      4'd8:  a = 21'd3667;
      4'd9:  a = 21'd1833;
      4'd10: a = 21'd917;
      4'd11: a = 21'd458;
      4'd12: a = 21'd229;
      4'd13: a = 21'd115;
      4'd14: a = 21'd57;
      4'd15: a = 21'd29;
    endcase
    return a;
  endfunction

endpackage

### hw/rtl/sorted_calibration_interpolation_table_unit.sv
// Add item: the CORDIC rotation, a scan of the entries up to the key, then a read and a write per shifted entry.
// Query item: a scan of the entries, plus a multiply and a 49-step divide when it interpolates.
// One item at a time; the next is taken once the result is in the output register.
// Reset empties the table and clears the enable register; no clearing pass is run.
// ----------------------------------------------------------------------------
// Sorted calibration interpolation table
// Frequency-sorted phase correction table with CORDIC sine, insert-in-order,
// and piecewise linear lookup through a serial divider.
// ----------------------------------------------------------------------------
module sorted_calibration_interpolation_table_unit #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                correction_enable,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                kind,
  input  logic [scit_pkg::FREQ_W-1:0]         frequency,
  input  logic signed [scit_pkg::ANG_W-1:0]   measured_phase,
  input  logic signed [scit_pkg::ANG_W-1:0]   known_azimuth,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [scit_pkg::CORR_W-1:0]  correction,
  output logic [scit_pkg::STAT_W-1:0]         status,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]    entry_count
);

  scit_pkg::cmd_t cmd;
  scit_pkg::sts_t sts;

  // The enable register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  // Sequencer.
  scit_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Table, arithmetic and output register.
  scit_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_valid         (cfg_valid),
    .correction_enable (correction_enable),
    .kind              (kind),
    .frequency         (frequency),
    .measured_phase    (measured_phase),
    .known_azimuth     (known_azimuth),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .correction        (correction),
    .status            (status),
    .entry_count       (entry_count)
  );

endmodule

### hw/rtl/scit_ctrl.sv
// ----------------------------------------------------------------------------
// Calibration table controller
// One-hot state machine that sequences the sine rotation, the table scan,
// the insert shift, the interpolation divide and the result hand-off.
// ----------------------------------------------------------------------------
module scit_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  scit_pkg::sts_t  sts,
  output scit_pkg::cmd_t  cmd
);

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_DISPATCH = 12'b0000_0000_0010,
    S_CORDIC   = 12'b0000_0000_0100,
    S_SCAN_RD  = 12'b0000_0000_1000,
    S_SCAN_CHK = 12'b0000_0001_0000,
    S_SHIFT_RD = 12'b0000_0010_0000,
    S_SHIFT_WR = 12'b0000_0100_0000,
    S_INSERT   = 12'b0000_1000_0000,
    S_MUL      = 12'b0001_0000_0000,
    S_DIV      = 12'b0010_0000_0000,
    S_INTERP   = 12'b0100_0000_0000,
    S_FIN      = 12'b1000_0000_0000
  } state_t;

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.query) begin
          if (!sts.enable || sts.empty) begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = scit_pkg::RES_ZERO;
            cmd.status   = scit_pkg::STATUS_QUERY;
            state_next   = S_FIN;
          end else begin
            state_next = S_SCAN_RD;
          end
        end else begin
          state_next = S_CORDIC;
        end
      end
      S_CORDIC: begin
        cmd.cordic_step = 1'b1;
        if (sts.cordic_last) begin
          state_next = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (sts.at_end) begin
          // No entry at or above the key.
          if (sts.query) begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = scit_pkg::RES_PREV;
            cmd.status   = scit_pkg::STATUS_QUERY;
            state_next   = S_FIN;
          end else if (sts.full) begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = scit_pkg::RES_ADD;
            cmd.status   = scit_pkg::STATUS_FULL;
            state_next   = S_FIN;
          end else begin
            state_next = S_INSERT;
          end
        end else begin
          cmd.rd_scan = 1'b1;
          state_next  = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (!sts.hit) begin
          cmd.scan_next = 1'b1;
          state_next    = S_SCAN_RD;
        end else if (sts.query) begin
          if (sts.eq || sts.first) begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = scit_pkg::RES_CUR;
            cmd.status   = scit_pkg::STATUS_QUERY;
            state_next   = S_FIN;
          end else begin
            state_next = S_MUL;
          end
        end else if (sts.eq) begin
          cmd.new_wr   = 1'b1;
          cmd.res_load = 1'b1;
          cmd.res_sel  = scit_pkg::RES_ADD;
          cmd.status   = scit_pkg::STATUS_UPDATED;
          state_next   = S_FIN;
        end else if (sts.full) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = scit_pkg::RES_ADD;
          cmd.status   = scit_pkg::STATUS_FULL;
          state_next   = S_FIN;
        end else begin
          cmd.shift_init = 1'b1;
          state_next     = S_SHIFT_RD;
        end
      end
      S_SHIFT_RD: begin
        cmd.rd_shift = 1'b1;
        state_next   = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        if (sts.shift_last) begin
          state_next = S_INSERT;
        end else begin
          state_next = S_SHIFT_RD;
        end
      end
      S_INSERT: begin
        cmd.new_wr    = 1'b1;
        cmd.count_inc = 1'b1;
        cmd.res_load  = 1'b1;
        cmd.res_sel   = scit_pkg::RES_ADD;
        cmd.status    = scit_pkg::STATUS_ADDED;
        state_next    = S_FIN;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_INTERP;
        end
      end
      S_INTERP: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = scit_pkg::RES_INTERP;
        cmd.status   = scit_pkg::STATUS_QUERY;
        state_next   = S_FIN;
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/scit_dp.sv
// ----------------------------------------------------------------------------
// Calibration table datapath
// Item registers, sine CORDIC, sorted table memory, scan and shift pointers,
// interpolation multiplier, serial divider and the output register.
// ----------------------------------------------------------------------------
module scit_dp #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  scit_pkg::cmd_t                           cmd,
  output scit_pkg::sts_t                           sts,
  input  logic                                     cfg_valid,
  input  logic                                     correction_enable,
  input  logic                                     kind,
  input  logic [scit_pkg::FREQ_W-1:0]              frequency,
  input  logic signed [scit_pkg::ANG_W-1:0]        measured_phase,
  input  logic signed [scit_pkg::ANG_W-1:0]        known_azimuth,
  input  logic                                     out_ready,
  output logic                                     out_valid,
  output logic signed [scit_pkg::CORR_W-1:0]       correction,
  output logic [scit_pkg::STAT_W-1:0]              status,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]         entry_count
);

  localparam int ADDR_W  = $clog2(TABLE_DEPTH);
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int ENTRY_W = scit_pkg::FREQ_W + scit_pkg::CORR_W;
  localparam int FW      = scit_pkg::FREQ_W;
  localparam int CW      = scit_pkg::CORR_W;
  localparam int XW      = scit_pkg::XY_W;
  localparam int ZW      = scit_pkg::Z_W;
  localparam int PW      = scit_pkg::PROD_W;
  localparam int DIV_CNT_W_L = scit_pkg::DIV_CNT_W;

  // Configuration and item registers.
  logic                              enable_q;
  logic                              kind_q;
  logic [FW-1:0]                     freq_q;
  logic signed [scit_pkg::ANG_W-1:0] phase_q;

  // CORDIC state.
  logic signed [XW-1:0]               x_q, y_q, dx, dy;
  logic signed [ZW-1:0]               z_q, at;
  logic [scit_pkg::STEP_W-1:0]        iter_q;
  logic signed [15:0]                 az_f;

  // Table pointers and memory.
  logic [CNT_W-1:0]   count_q, idx_q;
  logic [ADDR_W-1:0]  sh_q;
  logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0] rdata, wdata;
  logic [ADDR_W-1:0]  waddr, raddr;
  logic               we, re;
  logic [FW-1:0]      rd_f, prev_f;
  logic signed [CW-1:0] rd_c, prev_c;

  // Interpolation.
  logic [PW-1:0]          dq;
  logic [FW-1:0]          rem_q, den_q;
  logic [DIV_CNT_W_L-1:0] dcnt;
  logic                   neg_q;
  logic signed [CW-1:0]   lo_c;
  logic signed [CW:0]     d17;
  logic [CW-1:0]          d_mag;
  logic [FW:0]            div_t;
  logic                   div_ge;
  logic [CW:0]            interp17;

  // Add correction and result.
  logic signed [XW-1:0] y_rnd, e_full;
  logic signed [CW-1:0] e16, add_corr;
  logic signed [CW:0]   diff;
  logic signed [CW-1:0] res_q;
  scit_pkg::status_t    stat_q;

  // Wrap the azimuth into one turn and fold it into the right half plane.
  always_comb begin
    az_f = {known_azimuth[scit_pkg::ANG_W-1], known_azimuth};
    if (az_f >= scit_pkg::HALF_TURN) begin
      az_f = 16'(az_f - scit_pkg::FULL_TURN);
    end
    if (az_f < -scit_pkg::HALF_TURN) begin
      az_f = 16'(az_f + scit_pkg::FULL_TURN);
    end
    if (az_f > scit_pkg::QUARTER_TURN) begin
      az_f = 16'(scit_pkg::HALF_TURN - az_f);
    end
    if (az_f < -scit_pkg::QUARTER_TURN) begin
      az_f = 16'(-scit_pkg::HALF_TURN - az_f);
    end
  end

  // One CORDIC rotation per step.
  always_comb begin
    dx = y_q >>> iter_q;
    dy = x_q >>> iter_q;
    at = ZW'(scit_pkg::atan_angle(iter_q));
  end

  // Expected phase rounded and clamped, then the saturated correction.
  always_comb begin
    y_rnd  = y_q + XW'(128);
    e_full = y_rnd >>> 8;
    if (e_full > scit_pkg::PHASE_LIMIT) begin
      e16 = 16'(scit_pkg::PHASE_LIMIT);
    end else if (e_full < -scit_pkg::PHASE_LIMIT) begin
      e16 = 16'(-scit_pkg::PHASE_LIMIT);
    end else begin
      e16 = e_full[CW-1:0];
    end
    diff = 17'(e16) - 17'(phase_q);
    if (diff > scit_pkg::CORR_LIMIT) begin
      add_corr = 16'(scit_pkg::CORR_LIMIT);
    end else if (diff < -scit_pkg::CORR_LIMIT) begin
      add_corr = 16'(-scit_pkg::CORR_LIMIT);
    end else begin
      add_corr = diff[CW-1:0];
    end
  end

  // Memory port selection.
  always_comb begin
    rd_f  = rdata[ENTRY_W-1:CW];
    rd_c  = rdata[CW-1:0];
    we    = cmd.shift_wr | cmd.new_wr;
    re    = cmd.rd_scan | cmd.rd_shift;
    waddr = cmd.shift_wr ? ADDR_W'(sh_q + 1'b1) : idx_q[ADDR_W-1:0];
    wdata = cmd.shift_wr ? rdata : {freq_q, add_corr};
    raddr = cmd.rd_shift ? sh_q : idx_q[ADDR_W-1:0];
  end

  // Table memory with registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  // Divider step and interpolated value.
  always_comb begin
    d17      = 17'(rd_c) - 17'(prev_c);
    d_mag    = d17[CW] ? CW'(-d17) : d17[CW-1:0];
    div_t    = {rem_q, dq[PW-1]};
    div_ge   = div_t >= {1'b0, den_q};
    interp17 = neg_q ? 17'(lo_c) - {1'b0, dq[CW-1:0]}
                     : 17'(lo_c) + {1'b0, dq[CW-1:0]};
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      enable_q  <= 1'b0;
      count_q   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        enable_q <= correction_enable;
      end
      if (cmd.count_inc) begin
        count_q <= count_q + 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q  <= kind;
      freq_q  <= frequency;
      phase_q <= measured_phase;
      x_q     <= XW'(scit_pkg::XY_INIT);
      y_q     <= '0;
      z_q     <= {az_f, 8'd0};
      iter_q  <= '0;
      idx_q   <= '0;
    end
    if (cmd.cordic_step) begin
      if (!z_q[ZW-1]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + at;
      end
      iter_q <= iter_q + 1'b1;
    end
    if (cmd.scan_next) begin
      prev_f <= rd_f;
      prev_c <= rd_c;
      idx_q  <= idx_q + 1'b1;
    end
    if (cmd.shift_init) begin
      sh_q <= ADDR_W'(count_q - 1'b1);
    end
    if (cmd.shift_wr) begin
      sh_q <= sh_q - 1'b1;
    end
    if (cmd.mul) begin
      dq    <= PW'(freq_q - prev_f) * PW'(d_mag);
      den_q <= rd_f - prev_f;
      rem_q <= '0;
      dcnt  <= '0;
      neg_q <= d17[CW];
      lo_c  <= prev_c;
    end
    if (cmd.div_step) begin
      rem_q <= div_ge ? FW'(div_t - {1'b0, den_q}) : div_t[FW-1:0];
      dq    <= {dq[PW-2:0], div_ge};
      dcnt  <= dcnt + 1'b1;
    end
    if (cmd.res_load) begin
      stat_q <= cmd.status;
      unique case (cmd.res_sel)
        scit_pkg::RES_ZERO:   res_q <= '0;
        scit_pkg::RES_ADD:    res_q <= add_corr;
        scit_pkg::RES_CUR:    res_q <= rd_c;
        scit_pkg::RES_PREV:   res_q <= prev_c;
        scit_pkg::RES_INTERP: res_q <= interp17[CW-1:0];
        default:              res_q <= '0;
      endcase
    end
    if (cmd.out_load) begin
      correction  <= res_q;
      status      <= stat_q;
      entry_count <= count_q;
    end
  end

  // Status toward the controller.
  always_comb begin
    sts.query       = kind_q;
    sts.enable      = enable_q;
    sts.empty       = count_q == '0;
    sts.full        = count_q == CNT_W'(TABLE_DEPTH);
    sts.cordic_last = iter_q == scit_pkg::STEP_W'(scit_pkg::CORDIC_STEPS - 1);
    sts.at_end      = idx_q == count_q;
    sts.hit         = rd_f >= freq_q;
    sts.eq          = rd_f == freq_q;
    sts.first       = idx_q == '0;
    sts.shift_last  = CNT_W'(sh_q) == idx_q;
    sts.div_last    = dcnt == DIV_CNT_W_L'(PW - 1);
    sts.out_busy    = out_valid && !out_ready;
  end

endmodule

### hw/rtl/scit_checker.sv
// ----------------------------------------------------------------------------
// Calibration table port checker
// Checks the result channel and the reported table fill at the ports.
// ----------------------------------------------------------------------------
module scit_checker #(
  parameter int TABLE_DEPTH = 16
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [scit_pkg::CORR_W-1:0]         correction,
  input logic [scit_pkg::STAT_W-1:0]         status,
  input logic [$clog2(TABLE_DEPTH+1)-1:0]    entry_count
);

  // A stalled result holds its item.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(correction) && $stable(status)
      && $stable(entry_count))
    else $error("result changed while stalled");

  // Nothing is offered right after reset.
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // A dropped point is reported only with a full table.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == scit_pkg::STATUS_FULL |-> entry_count == TABLE_DEPTH)
    else $error("table full reported with free entries");

  // An added or updated point leaves at least one entry.
  a_add_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == scit_pkg::STATUS_ADDED || status == scit_pkg::STATUS_UPDATED)
      |-> entry_count != 0)
    else $error("stored point with empty table");

  // The fill never exceeds the table.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> entry_count <= TABLE_DEPTH)
    else $error("entry count beyond table depth");

endmodule

bind sorted_calibration_interpolation_table_unit scit_checker #(
  .TABLE_DEPTH (TABLE_DEPTH)
) u_scit_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .correction  (correction),
  .status      (status),
  .entry_count (entry_count)
);
